FILE: src/sc3_pkg.sv
package sc3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int LB_ADDR_W = $clog2(MAX_WIDTH);
  localparam int CH_N      = 3;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 16;
  localparam int WIDTH_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
  localparam logic [ROW_W-1:0]   HEIGHT_MIN   = ROW_W'(1);
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);
  localparam logic [7:0]         CLAMP_MAX    = 8'd255;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

  typedef logic [CH_N-1:0][7:0] pix_t;

  typedef struct packed {
    pix_t two_above;
    pix_t above;
  } lb_entry_t;

  typedef struct packed {
    logic [7:0] pix_ch0;
    logic [7:0] pix_ch1;
    logic [7:0] pix_ch2;
    logic       flush;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [7:0]       out_ch0;
    logic [7:0]       out_ch1;
    logic [7:0]       out_ch2;
    logic             image_done;
  } out_word_t;

endpackage

FILE: src/sc3_lane.sv
module sc3_lane
  import sc3_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] top,
  input  logic [7:0] left,
  input  logic [7:0] mid,
  input  logic [7:0] right,
  input  logic [7:0] bottom,
  output logic [7:0] res_r
);

  logic signed [11:0] sum;
  logic [7:0]         res_nxt;

  always_comb begin
    sum = $signed({2'b00, mid, 2'b00}) + $signed({4'b0000, mid})
        - $signed({4'b0000, top}) - $signed({4'b0000, left})
        - $signed({4'b0000, right}) - $signed({4'b0000, bottom});
    if (sum[11]) begin
      res_nxt = 8'd0;
    end else if (sum > $signed({4'b0000, CLAMP_MAX})) begin
      res_nxt = CLAMP_MAX;
    end else begin
      res_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: src/sc3_line_ram.sv
module sc3_line_ram
  import sc3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [LB_ADDR_W-1:0] rd_addr,
  output lb_entry_t            rd_data,
  input  logic                 wr_en,
  input  logic [LB_ADDR_W-1:0] wr_addr,
  input  lb_entry_t            wr_data
);

  lb_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: src/sharpen_conv3x3_clamp_unit.sv
// 3x3 sharpen filter with clamping on a raster stream of three-channel pixels.
// The input channel takes one pixel word per cycle in raster order; after the
// image the source sends one row of flush words that stands for a zero row
// below it. The result channel gives one word for each center pixel off the
// first and last columns: row, column, three clamped channels, last-word flag.
// Throughput is one input word per cycle while the result channel does not
// stall, set by the line memory, which takes one read and one write per cycle.
// A result word passes two register stages, stage one and the output stage.
// Input words in the first two columns of a row and the whole first input row
// give no result, so the border columns of the image give none either.
// The configuration port is always ready; it sets the image width and height
// and must only be written while the block is idle.
// A stall on the result channel while a result word waits holds the whole
// pipeline and asserts the input stall in the same cycle, so no word is lost
// or repeated.
// Synchronous reset empties the pipeline, returns the position counters to
// the start of an image and loads the default size of 640 by 480. The line
// memory is not cleared: the first row of every image is never used as a row
// above without having been written.
module sharpen_conv3x3_clamp_unit
  import sc3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [WIDTH_W-1:0] width_eff;
  logic [WIDTH_W-1:0] width_m1;
  logic [ROW_W-1:0]   height_eff;

  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;

  logic advance;
  logic accept;
  logic end_row;
  logic end_image;
  pix_t in_pix;

  logic             s1_valid_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_emit_r;
  logic             s1_top_zero_r;
  logic             s1_done_r;

  pix_t      win_r [6];
  lb_entry_t rd_entry;
  lb_entry_t wr_entry;
  logic      shift_en;

  logic [7:0] lane_res [CH_N];

  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_done_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (width_r > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = width_r;
    end
    width_m1   = width_eff - WIDTH_W'(1);
    height_eff = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
  end

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  always_comb begin
    end_row   = {1'b0, col_r} >= width_m1;
    end_image = end_row && (row_r >= height_eff);
    if (in_word.flush || (row_r >= height_eff)) begin
      in_pix = '0;
    end else begin
      in_pix = {in_word.pix_ch2, in_word.pix_ch1, in_word.pix_ch0};
    end
    if (end_image) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (end_row) begin
      row_nxt = row_r + ROW_W'(1);
      col_nxt = '0;
    end else begin
      row_nxt = row_r;
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_pix;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_emit_r     <= (row_r != '0) && (col_r >= COL_W'(2));
      s1_top_zero_r <= (row_r == ROW_W'(1));
      s1_done_r     <= end_image;
    end
  end

  assign shift_en          = s1_valid_r && advance;
  assign wr_entry.two_above = rd_entry.above;
  assign wr_entry.above     = s1_pix_r;

  sc3_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r[LB_ADDR_W-1:0]),
    .rd_data (rd_entry),
    .wr_en   (shift_en),
    .wr_addr (s1_col_r[LB_ADDR_W-1:0]),
    .wr_data (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= rd_entry.above;
      win_r[3] <= win_r[4];
      win_r[4] <= rd_entry.two_above;
      win_r[5] <= s1_pix_r;
    end
  end

  for (genvar k = 0; k < CH_N; k++) begin : g_lane
    sc3_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .top    (s1_top_zero_r ? 8'd0 : win_r[4][k]),
      .left   (win_r[1][k]),
      .mid    (win_r[2][k]),
      .right  (rd_entry.above[k]),
      .bottom (win_r[5][k]),
      .res_r  (lane_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row_r  <= s1_row_r - ROW_W'(1);
      out_col_r  <= s1_col_r - COL_W'(1);
      out_done_r <= s1_done_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_word.out_row    = out_row_r;
  assign out_word.out_col    = out_col_r;
  assign out_word.out_ch0    = lane_res[0];
  assign out_word.out_ch1    = lane_res[1];
  assign out_word.out_ch2    = lane_res[2];
  assign out_word.image_done = out_done_r;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("stage one word dropped during a stall");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r && advance |=> out_valid_r)
    else $error("interior word gave no result");

  a_end_image: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_image |=> (row_r == '0) && (col_r == '0))
    else $error("counters did not restart after the last word of the image");

  a_out_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_col_r != '0) && ({1'b0, out_col_r} < WIDTH_MAX))
    else $error("result column on the border");
`endif

endmodule

FILE: sim/sharpen_conv3x3_clamp_unit_test.sv
`timescale 1ns / 1ps

module sharpen_conv3x3_clamp_unit_test
  import sc3_pkg::*;
();

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int SETTLE_CYCLES = 8;
  localparam int NARROW_WIDTH = 40;

  localparam cfg_idx_t REG_UNMAPPED_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_UNMAPPED_B = cfg_idx_t'(3);

  localparam int CUT_ANY = -1;
  localparam int CUT_HEIGHT = 0;
  localparam int CUT_WIDTH = 1;
  localparam int CUT_UNMAPPED = 2;

  typedef struct {
    bit                    is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    in_word_t              word;
    bit                    typed;
    out_word_t             want;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sharpen_conv3x3_clamp_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  logic [WIDTH_W-1:0] width_reg;
  logic [ROW_W-1:0]   height_reg;
  logic [23:0]        prev_line [MAX_WIDTH];
  logic [23:0]        prev2_line [MAX_WIDTH];
  logic [23:0]        win [6];
  logic [ROW_W-1:0]   pos_row;
  logic [COL_W-1:0]   pos_col;

  out_word_t  expected_px[$];
  probe_row_t probe_rows[$];
  out_word_t  head;
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  bit         hold_done = 0;

  function automatic int eff_width();
    if (width_reg < WIDTH_MIN) return int'(WIDTH_MIN);
    if (width_reg > WIDTH_MAX) return int'(WIDTH_MAX);
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < HEIGHT_MIN) return int'(HEIGHT_MIN);
    return int'(height_reg);
  endfunction

  function automatic logic [7:0] sharpen_ch(input logic [23:0] t, l, m, rt, b, input int k);
    int s;
    s = 5 * int'(m[8*k +: 8]) - int'(t[8*k +: 8]) - int'(l[8*k +: 8])
        - int'(rt[8*k +: 8]) - int'(b[8*k +: 8]);
    if (s < 0) s = 0;
    if (s > int'(CLAMP_MAX)) s = int'(CLAMP_MAX);
    return 8'(s);
  endfunction

  function automatic bit filter_step(input in_word_t w, output out_word_t res,
                                     output bit img_end);
    int          wd;
    int          ht;
    int          c;
    int          r;
    logic [23:0] px;
    logic [23:0] above;
    logic [23:0] two_up;
    logic [23:0] bottom;
    logic [23:0] top;
    bit          end_row;
    bit          got;
    wd = eff_width();
    ht = eff_height();
    c = int'(pos_col);
    r = int'(pos_row);
    px = {w.pix_ch2, w.pix_ch1, w.pix_ch0};
    if (w.flush || r >= ht) px = '0;
    above = prev_line[c];
    two_up = prev2_line[c];
    bottom = win[5];
    win[0] = win[1];
    win[1] = win[2];
    win[2] = above;
    win[3] = win[4];
    win[4] = two_up;
    win[5] = px;
    prev2_line[c] = above;
    prev_line[c] = px;
    end_row = c >= wd - 1;
    img_end = end_row && r >= ht;
    got = 0;
    res = '0;
    if (r >= 1 && c >= 2) begin
      top = (r == 1) ? '0 : win[3];
      res.out_row = ROW_W'(r - 1);
      res.out_col = COL_W'(c - 1);
      res.out_ch0 = sharpen_ch(top, win[0], win[1], win[2], bottom, 0);
      res.out_ch1 = sharpen_ch(top, win[0], win[1], win[2], bottom, 1);
      res.out_ch2 = sharpen_ch(top, win[0], win[1], win[2], bottom, 2);
      res.image_done = img_end;
      got = 1;
    end
    if (img_end) begin
      pos_row = '0;
      pos_col = '0;
    end else if (end_row) begin
      pos_row = ROW_W'(r + 1);
      pos_col = '0;
    end else begin
      pos_col = COL_W'(c + 1);
    end
    return got;
  endfunction

  function automatic in_word_t mk_word(input int c0, c1, c2, input bit fl);
    in_word_t w;
    w.pix_ch0 = 8'(c0);
    w.pix_ch1 = 8'(c1);
    w.pix_ch2 = 8'(c2);
    w.flush = fl;
    return w;
  endfunction

  function automatic out_word_t mk_result(input int row, col, c0, c1, c2, input bit done);
    out_word_t o;
    o.out_row = ROW_W'(row);
    o.out_col = COL_W'(col);
    o.out_ch0 = 8'(c0);
    o.out_ch1 = 8'(c1);
    o.out_ch2 = 8'(c2);
    o.image_done = done;
    return o;
  endfunction

  function automatic void add_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    probe_row_t p;
    p = '{default: '0};
    p.is_cfg = 1;
    p.idx = idx;
    p.data = data;
    probe_rows.push_back(p);
  endfunction

  function automatic void add_item(input in_word_t w, input bit typed, input out_word_t want);
    probe_row_t p;
    p = '{default: '0};
    p.word = w;
    p.typed = typed;
    p.want = want;
    probe_rows.push_back(p);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic send_item(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_W-1:0];
    else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_cut(input int kind);
    drain_pipe();
    if (kind == CUT_ANY) kind = $urandom_range(CUT_HEIGHT, CUT_UNMAPPED);
    case (kind)
      CUT_HEIGHT: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
      CUT_WIDTH: begin
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0,
                  (eff_width() > NARROW_WIDTH) ? NARROW_WIDTH : eff_width())));
      end
      default: begin
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
                  CFG_DATA_W'($urandom));
      end
    endcase
  endtask

  task automatic send_image(input int cut_at, input int cut_kind, output int count);
    bit        finished;
    bit        got;
    out_word_t res;
    in_word_t  w;
    count = 0;
    finished = 0;
    while (!finished) begin
      if (cut_at != 0 && count == cut_at) apply_cut(cut_kind);
      if (eff_height() > 64 && pos_row >= 6) apply_cut(CUT_HEIGHT);
      w.pix_ch0 = 8'($urandom_range(0, 255));
      w.pix_ch1 = 8'($urandom_range(0, 255));
      w.pix_ch2 = 8'($urandom_range(0, 255));
      if (int'(pos_row) >= eff_height()) w.flush = ($urandom_range(0, 15) != 0);
      else w.flush = ($urandom_range(0, 15) == 0);
      send_item(w);
      got = filter_step(w, res, finished);
      if (got) expected_px.push_back(res);
      count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        flag_mismatch("word with nothing expected, out_row", int'(out_word.out_row), -1);
      end else begin
        head = expected_px.pop_front();
        if (out_word.out_row !== head.out_row)
          flag_mismatch("out_row", int'(out_word.out_row), int'(head.out_row));
        if (out_word.out_col !== head.out_col)
          flag_mismatch("out_col", int'(out_word.out_col), int'(head.out_col));
        if (out_word.out_ch0 !== head.out_ch0)
          flag_mismatch("out_ch0", int'(out_word.out_ch0), int'(head.out_ch0));
        if (out_word.out_ch1 !== head.out_ch1)
          flag_mismatch("out_ch1", int'(out_word.out_ch1), int'(head.out_ch1));
        if (out_word.out_ch2 !== head.out_ch2)
          flag_mismatch("out_ch2", int'(out_word.out_ch2), int'(head.out_ch2));
        if (out_word.image_done !== head.image_done)
          flag_mismatch("image_done", int'(out_word.image_done), int'(head.image_done));
      end
    end
  end

  initial begin
    int span;
    int pct;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && results_seen >= 150 && in_valid) begin
        hold_done = 1;
        repeat (400) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      span = $urandom_range(10, 120);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 20;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (span) begin
        @(negedge clk);
        out_stall = ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    bit        got;
    bit        img_end;
    out_word_t res;
    out_word_t none;
    int        p;
    int        n;
    int        rand_items;
    int        wv;
    int        images;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      prev_line[i] = '0;
      prev2_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    pos_row = '0;
    pos_col = '0;
    none = '0;

    // Start at the reset size, then shrink the width mid-row and the height mid-image.
    add_item(mk_word(12, 34, 56, 0), 0, none);
    add_item(mk_word(200, 100, 50, 0), 0, none);
    add_item(mk_word(255, 255, 255, 1), 0, none);
    add_write(REG_IMAGE_WIDTH, 16'hF003);
    add_item(mk_word(9, 9, 9, 0), 0, none);
    add_item(mk_word(1, 2, 3, 0), 0, none);
    add_item(mk_word(4, 5, 6, 0), 0, none);
    add_item(mk_word(7, 8, 9, 0), 0, none);
    add_write(REG_IMAGE_HEIGHT, 16'd0);
    add_item(mk_word(77, 0, 255, 0), 0, none);
    add_item(mk_word(1, 1, 1, 1), 0, none);
    add_item(mk_word(0, 255, 0, 0), 0, none);
    add_write(REG_IMAGE_WIDTH, 16'd0);
    add_write(REG_UNMAPPED_A, 16'hFFFF);
    add_write(REG_UNMAPPED_B, 16'h1234);
    // Pixels in the zero row below the image must read as zero even without flush.
    add_item(mk_word(0, 0, 0, 0), 0, none);
    add_item(mk_word(51, 51, 51, 0), 0, none);
    add_item(mk_word(0, 0, 0, 0), 0, none);
    add_item(mk_word(255, 255, 255, 0), 0, none);
    add_item(mk_word(255, 255, 255, 0), 0, none);
    add_item(mk_word(255, 255, 255, 0), 1, mk_result(0, 1, 255, 255, 255, 1));
    add_item(mk_word(255, 255, 255, 0), 0, none);
    add_item(mk_word(0, 0, 0, 0), 0, none);
    add_item(mk_word(255, 255, 255, 0), 0, none);
    add_item(mk_word(0, 0, 0, 1), 0, none);
    add_item(mk_word(0, 0, 0, 1), 0, none);
    add_item(mk_word(0, 0, 0, 1), 1, mk_result(0, 1, 0, 0, 0, 1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].is_cfg) begin
        drain_pipe();
        write_reg(probe_rows[i].idx, probe_rows[i].data);
      end else begin
        send_item(probe_rows[i].word);
        got = filter_step(probe_rows[i].word, res, img_end);
        if (probe_rows[i].typed) expected_px.push_back(probe_rows[i].want);
        else if (got) expected_px.push_back(res);
      end
    end

    p = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      drain_pipe();
      if (p == 1) begin
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        send_image(10, CUT_WIDTH, n);
        rand_items += n;
      end else if (p == 3) begin
        write_reg(REG_IMAGE_WIDTH, 16'd2048);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_image(10, CUT_WIDTH, n);
        rand_items += n;
      end else begin
        case ($urandom_range(0, 9))
          0: wv = $urandom_range(0, 2);
          1: wv = $urandom_range(13, 40);
          default: wv = $urandom_range(3, 12);
        endcase
        if ($urandom_range(0, 1)) begin
          write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(wv)});
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 5)));
        end else begin
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 5)));
          write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(wv)});
        end
        if ($urandom_range(0, 5) == 0)
          write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
                    CFG_DATA_W'($urandom));
        images = $urandom_range(1, 3);
        repeat (images) begin
          if ($urandom_range(0, 3) == 0)
            send_image($urandom_range(1, 2 * eff_width()), CUT_ANY, n);
          else
            send_image(0, CUT_ANY, n);
          rand_items += n;
          if ($urandom_range(0, 3) == 0) drain_pipe();
        end
      end
      p++;
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
